/* rtl/fkw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fkw_pkg
// Shared types and fixed-point constants of the filter kernel weight core.
// ----------------------------------------------------------------------------
package fkw_pkg;

	// filter kind codes as held in the filter_kind register
	typedef enum logic [2:0] {
		KIND_BOX      = 3'd0,
		KIND_TENT     = 3'd1,
		KIND_GAUSS    = 3'd2,
		KIND_MITCHELL = 3'd3,
		KIND_QUAD     = 3'd4,
		KIND_CUBIC    = 3'd5,
		KIND_CATROM   = 3'd6,
		KIND_ZERO     = 3'd7
	} fkw_kind_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} fkw_adv_t;

	// register word index of filter_kind on the APB port
	localparam logic REG_FILTER_KIND = 1'b0;

	// field widths
	localparam int OFFSET_W = 16;
	localparam int WEIGHT_W = 18;
	localparam int MAG_W    = 17;   // |offset|, 0..32768
	localparam int GAUSS_W  = 15;   // Gaussian table entry, at most 16338

	// polynomial pipeline: final Horner sum, biased so that it is never negative
	localparam int P3_W = 56;

	// offset 1.0 in Q2.14 and weight 1.0 in Q2.16
	localparam logic [MAG_W-1:0]    UNIT_Q14   = 17'd16384;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 18'd65536;

	// rounding divide: weight = floor(p3 / (DIV_DEN * 2^DIV_FRAC)) - 1.0
	localparam int DIV_FRAC  = 17;
	localparam int DIV_X_W   = 31;
	localparam int DIV_SHIFT = 45;
	localparam logic [31:0] DIV_RECIP = 32'd3909374677;   // ceil(2^45 / 9000)

endpackage : fkw_pkg
`default_nettype wire

/* rtl/fkw_gauss_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fkw_gauss_rom
// Gaussian weight table over |offset| in [0,2), filled at elaboration.
// Two stages: table index from the magnitude, then the registered read.
// ----------------------------------------------------------------------------
module fkw_gauss_rom #(
	parameter int GAUSS_TABLE_DEPTH = 256
) (
	input  wire                       clk,
	input  fkw_pkg::fkw_adv_t         adv,
	input  wire [fkw_pkg::MAG_W-1:0]  mag,
	output logic [fkw_pkg::GAUSS_W-1:0] entry
);
	import fkw_pkg::*;

	localparam int IDX_W = $clog2(GAUSS_TABLE_DEPTH);
	localparam int DEP_W = $clog2(GAUSS_TABLE_DEPTH + 1);
	localparam int FULL_W = MAG_W + DEP_W - 15;
	localparam logic [FULL_W-1:0] LAST_IDX = FULL_W'(GAUSS_TABLE_DEPTH - 1);

	localparam longint unsigned Q30_ONE    = 64'd1073741824;
	localparam longint unsigned EXP_M1_Q30 = 64'd395007542;
	localparam longint unsigned PEAK_Q30   = 64'd267683837;

	// 0.2493*exp(-4.5*x*x) at x = 2i/depth, Q2.16
	function automatic logic [GAUSS_W-1:0] gauss_entry(input longint unsigned i);
		longint unsigned y;
		longint unsigned k;
		longint unsigned f;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned e;
		longint unsigned n;
		y = ((64'd18 * i * i) << 30) / (GAUSS_TABLE_DEPTH * GAUSS_TABLE_DEPTH);
		k = y >> 30;
		f = y & (Q30_ONE - 64'd1);
		// Taylor sum of exp(-f), each term truncated
		term = Q30_ONE;
		sum  = Q30_ONE;
		term = ((term * f) >> 30) / 64'd1;   sum = sum - term;
		term = ((term * f) >> 30) / 64'd2;   sum = sum + term;
		term = ((term * f) >> 30) / 64'd3;   sum = sum - term;
		term = ((term * f) >> 30) / 64'd4;   sum = sum + term;
		term = ((term * f) >> 30) / 64'd5;   sum = sum - term;
		term = ((term * f) >> 30) / 64'd6;   sum = sum + term;
		term = ((term * f) >> 30) / 64'd7;   sum = sum - term;
		term = ((term * f) >> 30) / 64'd8;   sum = sum + term;
		term = ((term * f) >> 30) / 64'd9;   sum = sum - term;
		term = ((term * f) >> 30) / 64'd10;  sum = sum + term;
		term = ((term * f) >> 30) / 64'd11;  sum = sum - term;
		term = ((term * f) >> 30) / 64'd12;  sum = sum + term;
		// one exp(-1) factor per integer part
		e = sum;
		for (n = 64'd0; n < 64'd24; n++) begin
			if (n < k) begin
				e = (e * EXP_M1_Q30 + (64'd1 << 29)) >> 30;
			end
		end
		return GAUSS_W'((e * PEAK_Q30 + (64'd1 << 43)) >> 44);
	endfunction

	logic [GAUSS_W-1:0] rom [GAUSS_TABLE_DEPTH];

	for (genvar g = 0; g < GAUSS_TABLE_DEPTH; g++) begin : g_rom
		assign rom[g] = gauss_entry(longint'(g));
	end

	// index = (mag * depth) >> 15, saturated at the last entry
	logic [MAG_W+DEP_W-1:0] idx_prod;
	logic [FULL_W-1:0]      idx_full;
	logic [IDX_W-1:0]       idx_d;

	assign idx_prod = MAG_W'(mag) * DEP_W'(GAUSS_TABLE_DEPTH);
	assign idx_full = idx_prod[MAG_W+DEP_W-1:15];
	assign idx_d    = (idx_full > LAST_IDX) ? IDX_W'(LAST_IDX) : IDX_W'(idx_full);

	logic [IDX_W-1:0]   idx_s2;
	logic [GAUSS_W-1:0] entry_s3;

	// register the index, then the table word
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			idx_s2 <= idx_d;
		end
		if (adv.s3) begin
			entry_s3 <= rom[idx_s2];
		end
	end

	assign entry = entry_s3;

endmodule : fkw_gauss_rom
`default_nettype wire

/* rtl/fkw_horner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fkw_horner
// Cubic spline kernels as one Horner pipeline. Per kind and interval the
// coefficients of N = k3*a^3 + k2*a^2 + k1*a + k0 are picked, all scaled to
// the common denominator 9000*2^17 per weight LSB, with the rounding offset
// and a one-unit bias folded into k0 so the sum is never negative.
// ----------------------------------------------------------------------------
module fkw_horner (
	input  wire                           clk,
	input  fkw_pkg::fkw_adv_t             adv,
	input  fkw_pkg::fkw_kind_t            kind,
	input  wire [fkw_pkg::MAG_W-1:0]      mag,
	output logic signed [fkw_pkg::P3_W-1:0] p3
);
	import fkw_pkg::*;

	localparam int A_W  = 15;   // magnitude inside any live interval, < 20480
	localparam int K3_W = 8;
	localparam int K2_W = 22;
	localparam int K1_W = 36;
	localparam int K0_W = 49;
	localparam int P1_W = 24;
	localparam int P2_W = 40;

	localparam longint SCALE_D  = 64'sd10240;   // 1/1.6 in Q2.14
	localparam longint DIV_DEN  = 64'sd9000;
	// half a weight LSB for rounding, plus 1.0 to keep the sum positive
	localparam longint ROUND_BIAS = DIV_DEN * ((64'sd1 << 16) + (64'sd1 << 33));

	typedef struct packed {
		logic signed [K3_W-1:0] k3;
		logic signed [K2_W-1:0] k2;
		logic signed [K1_W-1:0] k1;
		logic signed [K0_W-1:0] k0;
	} fkw_coef_t;

	// pick the interval's coefficients; outside the support all but the k0 bias are zero
	function automatic fkw_coef_t coef_sel(input fkw_kind_t k, input logic [MAG_W-1:0] a);
		longint c3;
		longint c2;
		longint c1;
		longint c0;
		fkw_coef_t r;
		c3 = 0;
		c2 = 0;
		c1 = 0;
		c0 = 0;
		unique case (k)
			KIND_MITCHELL: begin
				if (a < MAG_W'(SCALE_D)) begin
					c3 = 84;  c2 = -144; c1 = 0;    c0 = 64;
				end else if (a < MAG_W'(2 * SCALE_D)) begin
					c3 = -28; c2 = 144;  c1 = -240; c0 = 128;
				end
			end
			KIND_QUAD: begin
				if (a < MAG_W'(SCALE_D / 2)) begin
					c3 = 0;   c2 = -72;  c1 = 0;    c0 = 54;
				end else if (a < MAG_W'(3 * SCALE_D / 2)) begin
					c3 = 0;   c2 = 36;   c1 = -108; c0 = 81;
				end
			end
			KIND_CUBIC: begin
				if (a < MAG_W'(SCALE_D)) begin
					c3 = 36;  c2 = -72;  c1 = 0;    c0 = 48;
				end else if (a < MAG_W'(2 * SCALE_D)) begin
					c3 = -12; c2 = 72;   c1 = -144; c0 = 96;
				end
			end
			KIND_CATROM: begin
				if (a < MAG_W'(SCALE_D)) begin
					c3 = 108; c2 = -180; c1 = 0;    c0 = 72;
				end else if (a < MAG_W'(2 * SCALE_D)) begin
					c3 = -36; c2 = 180;  c1 = -288; c0 = 144;
				end
			end
			default: begin
			end
		endcase
		r.k3 = K3_W'(c3);
		r.k2 = K2_W'(c2 * SCALE_D);
		r.k1 = K1_W'(c1 * SCALE_D * SCALE_D);
		r.k0 = K0_W'(c0 * SCALE_D * SCALE_D * SCALE_D + ROUND_BIAS);
		return r;
	endfunction

	fkw_coef_t         coef;
	logic [A_W-1:0]    a_in;
	logic signed [P1_W-1:0] p1_d;

	// the low bits suffice: outside the support every a term is zeroed
	assign coef = coef_sel(kind, mag);
	assign a_in = mag[A_W-1:0];
	assign p1_d = P1_W'(coef.k3) * P1_W'($signed({1'b0, a_in})) + P1_W'(coef.k2);

	logic signed [P1_W-1:0] p1_s2;
	logic [A_W-1:0]         a_s2;
	logic signed [K1_W-1:0] k1_s2;
	logic signed [K0_W-1:0] k0_s2;
	logic signed [P2_W-1:0] p2_s3;
	logic [A_W-1:0]         a_s3;
	logic signed [K0_W-1:0] k0_s3;
	logic signed [P3_W-1:0] p3_s4;

	// advance the three Horner steps, one multiply per stage
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			p1_s2 <= p1_d;
			a_s2  <= a_in;
			k1_s2 <= coef.k1;
			k0_s2 <= coef.k0;
		end
		if (adv.s3) begin
			p2_s3 <= P2_W'(p1_s2) * P2_W'($signed({1'b0, a_s2})) + P2_W'(k1_s2);
			a_s3  <= a_s2;
			k0_s3 <= k0_s2;
		end
		if (adv.s4) begin
			p3_s4 <= P3_W'(p2_s3) * P3_W'($signed({1'b0, a_s3})) + P3_W'(k0_s3);
		end
	end

	assign p3 = p3_s4;

endmodule : fkw_horner
`default_nettype wire

/* rtl/filter_kernel_weight_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// filter_kernel_weight_core
// Reconstruction filter weight for one signed Q2.14 offset per cycle.
// ----------------------------------------------------------------------------
// Takes one offset word per clock and presents its Q2.16 weight on the weight
// port in order, once it has passed every stage; a stall on the output backs up
// through the six stage valid bits, so empty stages keep taking words until
// the pipe is full.
// The kind is sampled from filter_kind when the offset is accepted. Box and
// tent are formed directly, the Gaussian is read from a table of
// GAUSS_TABLE_DEPTH entries built at elaboration (no fill pass after reset),
// and the spline kinds run through a three-multiply Horner chain and a
// reciprocal divide by 9000; the 31x32 reciprocal multiply and the 40x16
// Horner multiply bound the clock.
// ----------------------------------------------------------------------------
module filter_kernel_weight_core #(
	parameter int GAUSS_TABLE_DEPTH = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	// input words
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  signed [15:0] offset,
	// result words
	output logic        out_valid,
	input  wire         out_stall,
	output logic signed [17:0] weight,
	// APB register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fkw_pkg::*;

	// ---------------- configuration register ----------------
	fkw_kind_t filter_kind_q;
	logic      cfg_wr;

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FILTER_KIND);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FILTER_KIND) ? 32'(filter_kind_q) : 32'd0;

	// hold the kind between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_kind_q <= KIND_BOX;
		end else if (cfg_wr) begin
			filter_kind_q <= fkw_kind_t'(pwdata[2:0]);
		end
	end

	// ---------------- stage flow control ----------------
	fkw_adv_t adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// a stage loads when it is empty or its word moves on
	always_comb begin
		adv.s6 = !v_s6 || !out_stall;
		adv.s5 = !v_s5 || adv.s6;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_stall  = !adv.s1;
	assign out_valid = v_s6;

	// advance valid bits with their words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
			if (adv.s6) v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: magnitude ----------------
	logic signed [MAG_W-1:0] off_x;
	logic [MAG_W-1:0]        mag_d;
	logic [MAG_W-1:0]        mag_s1;
	fkw_kind_t               kind_s1;

	assign off_x = MAG_W'(offset);
	assign mag_d = off_x[MAG_W-1] ? MAG_W'(-off_x) : MAG_W'(off_x);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			mag_s1  <= mag_d;
			kind_s1 <= filter_kind_q;
		end
	end

	// ---------------- stage 2: box and tent ----------------
	logic [WEIGHT_W-1:0] side_d;
	logic [MAG_W-1:0]    tent_base;

	assign tent_base = UNIT_Q14 - mag_s1;

	always_comb begin
		side_d = '0;
		if (mag_s1 <= UNIT_Q14) begin
			case (kind_s1)
				KIND_BOX:  side_d = WEIGHT_ONE;
				KIND_TENT: side_d = WEIGHT_W'({tent_base, 2'b00});
				default:   side_d = '0;
			endcase
		end
	end

	logic [WEIGHT_W-1:0] side_s2;
	fkw_kind_t           kind_s2;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			side_s2 <= side_d;
			kind_s2 <= kind_s1;
		end
	end

	// ---------------- Gaussian table and spline pipeline ----------------
	logic [GAUSS_W-1:0]      gauss_entry_s3;
	logic signed [P3_W-1:0]  p3_s4;

	fkw_gauss_rom #(
		.GAUSS_TABLE_DEPTH(GAUSS_TABLE_DEPTH)
	) u_gauss_rom (
		.clk   (clk),
		.adv   (adv),
		.mag   (mag_s1),
		.entry (gauss_entry_s3)
	);

	fkw_horner u_horner (
		.clk  (clk),
		.adv  (adv),
		.kind (kind_s1),
		.mag  (mag_s1),
		.p3   (p3_s4)
	);

	// ---------------- stage 3: carry side value while the table is read ----
	logic [WEIGHT_W-1:0] side_s3;
	fkw_kind_t           kind_s3;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			side_s3 <= side_s2;
			kind_s3 <= kind_s2;
		end
	end

	// ---------------- stage 4: merge the table word ----------------
	logic [WEIGHT_W-1:0] side_s4;
	fkw_kind_t           kind_s4;

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			side_s4 <= (kind_s3 == KIND_GAUSS) ? WEIGHT_W'(gauss_entry_s3) : side_s3;
			kind_s4 <= kind_s3;
		end
	end

	// ---------------- stage 5: reciprocal multiply ----------------
	logic [DIV_X_W-1:0]    quo_x;
	logic [DIV_X_W+31:0]   prod_s5;
	logic [WEIGHT_W-1:0]   side_s5;
	fkw_kind_t             kind_s5;

	// drop the power-of-two part of the divisor
	assign quo_x = p3_s4[DIV_FRAC+DIV_X_W-1:DIV_FRAC];

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			prod_s5 <= (DIV_X_W+32)'(quo_x) * (DIV_X_W+32)'(DIV_RECIP);
			side_s5 <= side_s4;
			kind_s5 <= kind_s4;
		end
	end

	// ---------------- stage 6: output register ----------------
	logic [WEIGHT_W-1:0] quo_q;
	logic                poly_k;
	logic [WEIGHT_W-1:0] weight_s6;
	fkw_kind_t           kind_s6;

	assign quo_q = prod_s5[DIV_SHIFT+WEIGHT_W-1:DIV_SHIFT];

	always_comb begin
		case (kind_s5) inside
			KIND_MITCHELL, KIND_QUAD, KIND_CUBIC, KIND_CATROM: poly_k = 1'b1;
			default:                                           poly_k = 1'b0;
		endcase
	end

	// remove the 1.0 bias from the quotient
	always_ff @(posedge clk) begin
		if (adv.s6) begin
			weight_s6 <= poly_k ? (quo_q - WEIGHT_ONE) : side_s5;
			kind_s6   <= kind_s5;
		end
	end

	assign weight = $signed(weight_s6);

	// ---------------- assertions ----------------
	// the input is held off only when every stage is full and the output stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	// kind changes only by a register write
	a_kind_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(psel && penable && pwrite) |=> $stable(filter_kind_q))
		else $error("filter_kind changed without a write");

	// biased Horner sum stays positive and inside the divider range
	a_p3_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (!p3_s4[P3_W-1] && (p3_s4[P3_W-2:DIV_FRAC+DIV_X_W] == '0)))
		else $error("Horner sum outside the divider range");

	// box, tent and Gaussian weights are never negative; kind seven is zero
	a_side_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && (kind_s6 == KIND_BOX || kind_s6 == KIND_TENT || kind_s6 == KIND_GAUSS))
		|-> !weight_s6[WEIGHT_W-1])
		else $error("negative weight from a non-spline kind");

	a_zero_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && kind_s6 == KIND_ZERO) |-> (weight_s6 == '0))
		else $error("nonzero weight for the zero kind");

endmodule : filter_kernel_weight_core
`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the filter kernel weight core.
// ----------------------------------------------------------------------------
// Offsets are fed through a queue into a valid/stall driver, and the expected
// Q2.16 weight of each accepted word is worked out in the bench from the
// kind last written over APB. Accepted weights are matched in order against
// those expectations. A short directed pass covers every kind near its
// breakpoints and two at -2.0. A random pass then steps through all kinds,
// with idle and stall bursts on both sides, save in its last phase. The kind
// register is only rewritten once the pipe has drained, and is read back.
// ----------------------------------------------------------------------------
module testbench;
	import fkw_pkg::*;

	localparam int GAUSS_DEPTH = 256;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int PHASE_WORDS = 75;
	localparam int DIRECTED_WORDS = 20;

	// fixed-point constants of the weight formulas
	localparam longint SPAN = 10240;             // |offset| of 1.0 after scaling by 1.6
	localparam longint SPAN2 = SPAN * SPAN;
	localparam longint SPAN3 = SPAN2 * SPAN;
	localparam longint UNIT_SCALE = 125 * 131072; // SPAN^3 / 2^16
	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned INV_E_Q30 = 64'd395007542;
	localparam longint unsigned PEAK_Q30 = 64'd267683837;

	// filter_kind sits at byte address 0
	localparam logic [2:0] KIND_ADDR = {REG_FILTER_KIND, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [17:0] weight;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic signed [15:0] offset_backlog[$];
	logic [17:0] weight_due[$];
	fkw_kind_t kind_now = KIND_BOX;
	int words_queued = 0;
	int words_checked = 0;
	int fail_count = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int stall_left = 0;
	bit offset_taken = 1'b0;
	bit calm = 1'b0;

	int knee_points[7] = '{0, 5120, 10240, 15360, 16384, 20480, 32768};

	filter_kernel_weight_core #(
		.GAUSS_TABLE_DEPTH(GAUSS_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.offset   (offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.weight   (weight),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock: period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// nearest integer of n/d for d > 0, ties toward plus infinity
	function automatic longint round_half_up(longint n, longint d);
		longint num;
		longint den;
		longint q;
		num = 2 * n + d;
		den = 2 * d;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	// Gaussian table entry idx: exp(-4.5*x*x) in Q30, scaled to Q2.16 peak
	function automatic longint gauss_weight(longint unsigned idx);
		longint unsigned depth2;
		longint unsigned y;
		longint unsigned k;
		longint unsigned f;
		longint unsigned term;
		longint unsigned e;
		longint sum;
		depth2 = GAUSS_DEPTH * GAUSS_DEPTH;
		y = ((64'd18 * idx * idx) << 30) / depth2;
		k = y >> 30;
		f = y & (Q30 - 1);
		term = Q30;
		sum = Q30;
		// Taylor sum of exp(-f), each term truncated
		for (int n = 1; n <= 12; n++) begin
			term = ((term * f) >> 30) / n;
			if (n % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		// multiply in one factor of exp(-1) per whole unit of y
		e = $unsigned(sum);
		for (longint unsigned n = 0; n < k; n++)
			e = (e * INV_E_Q30 + (64'd1 << 29)) >> 30;
		return $signed((e * PEAK_Q30 + (64'd1 << 43)) >> 44);
	endfunction

	// weight of one offset under one filter kind, 18-bit two's complement
	function automatic logic [17:0] filter_weight(fkw_kind_t kind, logic signed [15:0] off);
		longint a;
		longint a2;
		longint a3;
		longint m;
		longint w;
		longint idx;
		a = (off < 0) ? -longint'(off) : longint'(off);
		a2 = a * a;
		a3 = a2 * a;
		w = 0;
		case (kind)
			KIND_BOX: w = (a > 16384) ? 0 : 65536;
			KIND_TENT: w = (a > 16384) ? 0 : (16384 - a) * 4;
			KIND_GAUSS: begin
				idx = (a * GAUSS_DEPTH) >>> 15;
				if (idx > GAUSS_DEPTH - 1)
					idx = GAUSS_DEPTH - 1;
				w = gauss_weight(idx);
			end
			KIND_MITCHELL: begin
				if (a < SPAN)
					w = round_half_up(16 * SPAN3 - 36 * a2 * SPAN + 21 * a3,
						18 * UNIT_SCALE);
				else if (a < 2 * SPAN)
					w = round_half_up(32 * SPAN3 - 60 * a * SPAN2 + 36 * a2 * SPAN - 7 * a3,
						18 * UNIT_SCALE);
			end
			KIND_QUAD: begin
				if (2 * a < SPAN)
					w = round_half_up(3 * SPAN3 - 4 * a2 * SPAN, 4 * UNIT_SCALE);
				else if (2 * a < 3 * SPAN) begin
					m = 2 * a - 3 * SPAN;
					w = round_half_up(m * m * SPAN, 8 * UNIT_SCALE);
				end
			end
			KIND_CUBIC: begin
				if (a < SPAN)
					w = round_half_up(3 * a3 - 6 * a2 * SPAN + 4 * SPAN3, 6 * UNIT_SCALE);
				else if (a < 2 * SPAN) begin
					m = 2 * SPAN - a;
					w = round_half_up(m * m * m, 6 * UNIT_SCALE);
				end
			end
			KIND_CATROM: begin
				if (a < SPAN)
					w = round_half_up(3 * a3 - 5 * a2 * SPAN + 2 * SPAN3, 2 * UNIT_SCALE);
				else if (a < 2 * SPAN)
					w = round_half_up(-a3 + 5 * a2 * SPAN - 8 * a * SPAN2 + 4 * SPAN3,
						2 * UNIT_SCALE);
			end
			default: w = 0;
		endcase
		return w[17:0];
	endfunction

	// drive offset words from the backlog, holding each until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !offset_taken) begin
			// hold the stalled word
		end else if (send_gap > 0) begin
			send_gap = send_gap - 1;
			in_valid <= 1'b0;
		end else if (offset_backlog.size() != 0) begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 9) - 1;
				in_valid <= 1'b0;
			end else begin
				offset <= offset_backlog.pop_front();
				in_valid <= 1'b1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// stall the weight side in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// record accepted offsets and check accepted weights in order
	always @(posedge clk) begin
		logic [17:0] want;
		offset_taken = arst_n && in_valid && !in_stall;
		if (offset_taken)
			weight_due.push_back(filter_weight(kind_now, offset));
		if (arst_n && out_valid && !out_stall) begin
			if (weight_due.size() == 0) begin
				$display("%0t: weight word with none due, actual %0d", $time, weight);
				fail_count = fail_count + 1;
			end else begin
				want = weight_due.pop_front();
				words_checked = words_checked + 1;
				if (weight !== want) begin
					$display("%0t: weight mismatch, expected %0d actual %0d",
						$time, $signed(want), weight);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// wait until every queued word has come back, then let the pipe settle
	task automatic drain_results();
		while (words_checked != words_queued)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// write filter_kind once the pipe is empty, then read it back
	task automatic write_kind(fkw_kind_t k);
		drain_results();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KIND_ADDR;
		pwdata <= {29'($urandom()), k};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		kind_now = k;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[2:0] !== k) begin
			$display("%0t: filter_kind readback, expected %0d actual %0d",
				$time, k, prdata[2:0]);
			fail_count = fail_count + 1;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// stimulus: directed breakpoints per kind, then random phases
	initial begin
		fkw_kind_t dir_kind[DIRECTED_WORDS];
		logic signed [15:0] dir_off[DIRECTED_WORDS];
		fkw_kind_t phase_kind[PHASES];
		int mode;
		int mag;
		logic signed [15:0] v;

		dir_kind = '{KIND_BOX, KIND_BOX, KIND_TENT, KIND_TENT,
			KIND_GAUSS, KIND_GAUSS, KIND_GAUSS,
			KIND_MITCHELL, KIND_MITCHELL, KIND_MITCHELL,
			KIND_QUAD, KIND_QUAD, KIND_QUAD, KIND_CUBIC, KIND_CUBIC,
			KIND_CATROM, KIND_CATROM, KIND_CATROM, KIND_ZERO, KIND_ZERO};
		dir_off = '{16'sd16384, 16'sd16385, -16'sd16384, 16'sd1,
			16'sd0, -16'sd32768, 16'sd32767,
			16'sd10239, 16'sd10240, 16'sd20480,
			16'sd5119, 16'sd5120, 16'sd15360, 16'sd20479, -16'sd32768,
			16'sd0, 16'sd10240, -16'sd20479, 16'sd32767, -16'sd1};
		phase_kind = '{KIND_GAUSS, KIND_MITCHELL, KIND_QUAD, KIND_CUBIC, KIND_CATROM,
			KIND_TENT, KIND_BOX, KIND_ZERO, KIND_BOX, KIND_BOX};
		phase_kind[8] = fkw_kind_t'($urandom_range(0, 7));
		phase_kind[9] = fkw_kind_t'($urandom_range(0, 7));

		// hold reset low, then release it
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words; the first group relies on the reset kind
		for (int i = 0; i < DIRECTED_WORDS; i++) begin
			if (dir_kind[i] != kind_now)
				write_kind(dir_kind[i]);
			offset_backlog.push_back(dir_off[i]);
			words_queued = words_queued + 1;
		end

		// random phases, the last one without idling
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				calm = 1'b1;
			write_kind(phase_kind[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				mode = $urandom_range(0, 9);
				if (mode < 3) begin
					v = 16'($urandom_range(0, 65535));
				end else begin
					if (mode < 7)
						mag = knee_points[$urandom_range(0, 6)] + int'($urandom_range(0, 128)) - 64;
					else
						mag = $urandom_range(0, 32768);
					if (mag < 0)
						mag = 0;
					if (mag > 32768)
						mag = 32768;
					// only -2.0 can carry magnitude 2.0
					if (mag == 32768 || $urandom_range(0, 1) == 1)
						v = 16'(-mag);
					else
						v = 16'(mag);
				end
				offset_backlog.push_back(v);
				words_queued = words_queued + 1;
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
